### src/jpeg_marker_stream_checker_assert.svh
// Assertion macros for the JPEG marker stream checker.
// Used by the top level; expects clk and rst_n in scope.
`ifndef JPEG_MARKER_STREAM_CHECKER_ASSERT_SVH
`define JPEG_MARKER_STREAM_CHECKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JMSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define JMSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication, checked in every cycle including reset.
`define JMSC_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

### src/jmsc_pkg.sv
// Shared types and constants for the JPEG marker stream checker.
// No dependencies.
package jmsc_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WANT_D8,
    PH_SEEK,
    PH_FILL,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD
  } phase_t;

  localparam logic [7:0] BYTE_FF  = 8'hff;
  localparam logic [7:0] BYTE_00  = 8'h00;
  localparam logic [7:0] BYTE_TEM = 8'h01;
  localparam logic [7:0] BYTE_SOI = 8'hd8;
  localparam logic [7:0] BYTE_EOI = 8'hd9;
  localparam logic [7:0] BYTE_SOS = 8'hda;
  localparam logic [7:0] BYTE_RST0 = 8'hd0;
  localparam logic [7:0] BYTE_RST7 = 8'hd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic valid;
    logic complete;
  } res_t;

endpackage

### src/jmsc_in_stage.sv
// Input register stage of the JPEG marker stream checker.
// Depends on jmsc_pkg.
module jmsc_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  jmsc_pkg::item_t in_item,
  input  logic           advance,
  output logic           in_stall,
  output logic           item_valid,
  output jmsc_pkg::item_t item
);

  logic            valid_r;
  logic            valid_nxt;
  jmsc_pkg::item_t item_r;

  assign in_stall   = valid_r && !advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

### src/jmsc_parser.sv
// Marker stream state machine and segment length counter.
// Depends on jmsc_pkg.
module jmsc_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_valid,
  input  jmsc_pkg::item_t item,
  input  logic            step,
  output jmsc_pkg::res_t  res
);

  jmsc_pkg::phase_t phase_r, phase_nxt;
  logic        in_scan_r, in_scan_nxt;
  logic        scan_seen_r, scan_seen_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] left_r, left_nxt;
  logic        is_sos_r, is_sos_nxt;

  logic [7:0]  b;
  logic        is_rst;
  logic        active;
  logic        verdict;
  logic        value;
  logic [15:0] size;
  logic [15:0] size_m2;

  assign b       = item.data_byte;
  assign is_rst  = (b >= jmsc_pkg::BYTE_RST0) && (b <= jmsc_pkg::BYTE_RST7);
  assign size    = {len_hi_r, b};
  assign size_m2 = size - 16'd2;

  // Verdict for the item in the input register
  always_comb begin
    active  = 1'b1;
    verdict = 1'b0;
    value   = 1'b0;
    if (item.first_byte) begin
      verdict = (b != jmsc_pkg::BYTE_FF);
    end else begin
      case (phase_r)
        jmsc_pkg::PH_WANT_D8: verdict = (b != jmsc_pkg::BYTE_SOI);
        jmsc_pkg::PH_SEEK:    verdict = (b != jmsc_pkg::BYTE_FF) && !in_scan_r;
        jmsc_pkg::PH_FILL: begin
          if (b == jmsc_pkg::BYTE_FF) begin
            verdict = 1'b0;
          end else if (in_scan_r && ((b == jmsc_pkg::BYTE_00) || is_rst)) begin
            verdict = 1'b0;
          end else if (b == jmsc_pkg::BYTE_EOI) begin
            verdict = 1'b1;
            value   = scan_seen_r;
          end else if ((b == jmsc_pkg::BYTE_SOI) || (b == jmsc_pkg::BYTE_00) || is_rst) begin
            verdict = 1'b1;
          end
        end
        jmsc_pkg::PH_LEN_HI:  verdict = 1'b0;
        jmsc_pkg::PH_LEN_LO:  verdict = (len_hi_r == 8'd0) && (b < 8'd2);
        jmsc_pkg::PH_PAYLOAD: verdict = 1'b0;
        default:              active  = 1'b0;
      endcase
    end
    res.valid    = item_valid && active && (verdict || item.last_byte);
    res.complete = value;
  end

  always_comb begin
    phase_nxt     = phase_r;
    in_scan_nxt   = in_scan_r;
    scan_seen_nxt = scan_seen_r;
    len_hi_nxt    = len_hi_r;
    left_nxt      = left_r;
    is_sos_nxt    = is_sos_r;
    if (step) begin
      if (item.first_byte) begin
        in_scan_nxt   = 1'b0;
        scan_seen_nxt = 1'b0;
        len_hi_nxt    = 8'd0;
        left_nxt      = 16'd0;
        is_sos_nxt    = 1'b0;
        phase_nxt     = (b == jmsc_pkg::BYTE_FF) ? jmsc_pkg::PH_WANT_D8 : jmsc_pkg::PH_IDLE;
      end else begin
        case (phase_r)
          jmsc_pkg::PH_WANT_D8: begin
            if (b == jmsc_pkg::BYTE_SOI) begin
              phase_nxt = jmsc_pkg::PH_SEEK;
            end
          end
          jmsc_pkg::PH_SEEK: begin
            if (b == jmsc_pkg::BYTE_FF) begin
              phase_nxt = jmsc_pkg::PH_FILL;
            end
          end
          jmsc_pkg::PH_FILL: begin
            if (b == jmsc_pkg::BYTE_FF) begin
              phase_nxt = jmsc_pkg::PH_FILL;
            end else if (in_scan_r && ((b == jmsc_pkg::BYTE_00) || is_rst)) begin
              phase_nxt = jmsc_pkg::PH_SEEK;
            end else if ((b == jmsc_pkg::BYTE_EOI) || (b == jmsc_pkg::BYTE_SOI) ||
                         (b == jmsc_pkg::BYTE_00) || is_rst) begin
              phase_nxt = jmsc_pkg::PH_FILL;
            end else if (b == jmsc_pkg::BYTE_TEM) begin
              phase_nxt = jmsc_pkg::PH_SEEK;
            end else begin
              in_scan_nxt = 1'b0;
              is_sos_nxt  = (b == jmsc_pkg::BYTE_SOS);
              phase_nxt   = jmsc_pkg::PH_LEN_HI;
            end
          end
          jmsc_pkg::PH_LEN_HI: begin
            len_hi_nxt = b;
            phase_nxt  = jmsc_pkg::PH_LEN_LO;
          end
          jmsc_pkg::PH_LEN_LO: begin
            if (!verdict) begin
              left_nxt = size_m2;
              if (size_m2 == 16'd0) begin
                if (is_sos_r) begin
                  in_scan_nxt   = 1'b1;
                  scan_seen_nxt = 1'b1;
                end
                phase_nxt = jmsc_pkg::PH_SEEK;
              end else begin
                phase_nxt = jmsc_pkg::PH_PAYLOAD;
              end
            end
          end
          jmsc_pkg::PH_PAYLOAD: begin
            left_nxt = left_r - 16'd1;
            if (left_r == 16'd1) begin
              if (is_sos_r) begin
                in_scan_nxt   = 1'b1;
                scan_seen_nxt = 1'b1;
              end
              phase_nxt = jmsc_pkg::PH_SEEK;
            end
          end
          default: phase_nxt = phase_r;
        endcase
      end
      if (res.valid) begin
        phase_nxt = jmsc_pkg::PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= jmsc_pkg::PH_IDLE;
      in_scan_r   <= 1'b0;
      scan_seen_r <= 1'b0;
      len_hi_r    <= 8'd0;
      left_r      <= 16'd0;
      is_sos_r    <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      in_scan_r   <= in_scan_nxt;
      scan_seen_r <= scan_seen_nxt;
      len_hi_r    <= len_hi_nxt;
      left_r      <= left_nxt;
      is_sos_r    <= is_sos_nxt;
    end
  end

endmodule

### src/jmsc_out_stage.sv
// Result register of the JPEG marker stream checker.
// Depends on jmsc_pkg.
module jmsc_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  jmsc_pkg::res_t res,
  input  logic           out_stall,
  output logic           out_valid,
  output logic           out_complete
);

  logic valid_r, valid_nxt;
  logic complete_r;

  assign out_valid    = valid_r;
  assign out_complete = complete_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      complete_r <= res.complete;
    end
  end

endmodule

### src/jpeg_marker_stream_checker.sv
// JPEG marker stream checker, top level.
// A byte passes the input register, then its verdict is loaded into the result register that drives out_valid.
// Throughput: one byte per cycle while in_stall is low; the parser state updates once per byte.
// A held result stalls the input only when the next byte also yields a verdict.
// Reset: synchronous active-low rst_n clears both stage valids and the parser.
// Depends on jmsc_pkg, jmsc_in_stage, jmsc_parser, jmsc_out_stage.
`include "jpeg_marker_stream_checker_assert.svh"
module jpeg_marker_stream_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_first_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_complete
);

  jmsc_pkg::item_t in_item;
  jmsc_pkg::item_t item;
  jmsc_pkg::res_t  res;
  logic            item_valid;
  logic            advance;
  logic            load;

  assign in_item.data_byte  = in_data_byte;
  assign in_item.first_byte = in_first_byte;
  assign in_item.last_byte  = in_last_byte;

  assign advance = item_valid && (!res.valid || !out_valid || !out_stall);
  assign load    = advance && res.valid;

  jmsc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .advance    (advance),
    .in_stall   (in_stall),
    .item_valid (item_valid),
    .item       (item)
  );

  jmsc_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .step       (advance),
    .res        (res)
  );

  jmsc_out_stage u_out_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (load),
    .res          (res),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_complete (out_complete)
  );

  `JMSC_ASSERT_NOW(a_hold_on_full, item_valid && res.valid && out_valid && out_stall, in_stall, "verdict pending while result held must stall input")
  `JMSC_ASSERT_NEXT(a_load_result, load, out_valid && (out_complete == $past(res.complete)), "loaded verdict not presented")
  `JMSC_ASSERT_NOW(a_no_result_no_load, !res.valid, !load, "result register loaded without a verdict")
  `JMSC_ASSERT_ALWAYS(a_reset_clear, $past(!rst_n), !out_valid && !item_valid, "stages not cleared by reset")

endmodule

### tb/jmsc_verdict_board_pkg.sv
// Verdict scoreboard for the JPEG marker stream checker: tracks the marker
// parse byte by byte and queues the verdict each stream should produce.
// Depends on jmsc_pkg.
package jmsc_verdict_board_pkg;
  import jmsc_pkg::*;

  class verdict_scoreboard;
    phase_t     phase = PH_IDLE;
    bit         in_scan = 1'b0;
    bit         scan_seen = 1'b0;
    logic [7:0] len_hi = '0;
    logic [15:0] payload_left = '0;
    bit         seg_is_sos = 1'b0;
    bit         expected_verdicts[$];
    int         mismatch_count = 0;

    function void restart();
      phase = PH_IDLE;
      in_scan = 1'b0;
      scan_seen = 1'b0;
      len_hi = '0;
      payload_left = '0;
      seg_is_sos = 1'b0;
    endfunction

    function void close_segment();
      if (seg_is_sos) begin
        in_scan = 1'b1;
        scan_seen = 1'b1;
      end
      phase = PH_SEEK;
    endfunction

    function bit is_rst(logic [7:0] b);
      return (b >= BYTE_RST0) && (b <= BYTE_RST7);
    endfunction

    function void note_byte(logic [7:0] b, logic first, logic last);
      bit verdict;
      bit value;
      logic [15:0] size;
      verdict = 1'b0;
      value = 1'b0;
      if (first) begin
        restart();
        if (b == BYTE_FF) phase = PH_WANT_D8;
        else verdict = 1'b1;
      end else begin
        case (phase)
          PH_IDLE: return;
          PH_WANT_D8: begin
            if (b == BYTE_SOI) phase = PH_SEEK;
            else verdict = 1'b1;
          end
          PH_SEEK: begin
            if (b == BYTE_FF) phase = PH_FILL;
            else if (!in_scan) verdict = 1'b1;
          end
          PH_FILL: begin
            if (b == BYTE_FF) begin
            end else if (in_scan && (b == BYTE_00 || is_rst(b))) begin
              phase = PH_SEEK;
            end else if (b == BYTE_EOI) begin
              verdict = 1'b1;
              value = scan_seen;
            end else if (b == BYTE_SOI || b == BYTE_00 || is_rst(b)) begin
              verdict = 1'b1;
            end else if (b == BYTE_TEM) begin
              phase = PH_SEEK;
            end else begin
              in_scan = 1'b0;
              seg_is_sos = (b == BYTE_SOS);
              phase = PH_LEN_HI;
            end
          end
          PH_LEN_HI: begin
            len_hi = b;
            phase = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            size = {len_hi, b};
            if (size < 16'd2) begin
              verdict = 1'b1;
            end else begin
              payload_left = size - 16'd2;
              if (payload_left == 16'd0) close_segment();
              else phase = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            payload_left = payload_left - 16'd1;
            if (payload_left == 16'd0) close_segment();
          end
          default: return;
        endcase
      end
      if (verdict || last) begin
        expected_verdicts.push_back(value);
        phase = PH_IDLE;
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
    endtask

    task check_verdict(logic got);
      bit want;
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("complete=%0b with no verdict pending", got));
      end else begin
        want = expected_verdicts.pop_front();
        if (got !== want)
          report_mismatch($sformatf("complete=%0b, expected %0b", got, want));
      end
    endtask

    function int outstanding();
      return expected_verdicts.size();
    endfunction
  endclass

endpackage

### tb/testbench.sv
// Testbench for jpeg_marker_stream_checker: feeds directed and random JPEG
// byte streams with random gaps and stalls, checks verdicts via the scoreboard.
// Depends on jmsc_pkg and jmsc_verdict_board_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import jmsc_pkg::*;
  import jmsc_verdict_board_pkg::*;

  localparam int ITEM_TARGET = 2000;
  localparam int IDLE_LIMIT = 5000;
  localparam logic [7:0] BYTE_APP0 = 8'he0;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_first_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_stall;
  logic       out_complete;

  verdict_scoreboard sb;
  logic [7:0] jpeg_bytes[$];
  bit sender_gaps;
  int items_sent;
  int quiet_cycles;

  jpeg_marker_stream_checker u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_first_byte(in_first_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_complete (out_complete)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(20, 60);
  endfunction

  function automatic void push_marker(logic [7:0] code);
    int fills;
    fills = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
    jpeg_bytes.push_back(BYTE_FF);
    repeat (fills) jpeg_bytes.push_back(BYTE_FF);
    jpeg_bytes.push_back(code);
  endfunction

  function automatic logic [7:0] plain_marker();
    logic [7:0] m;
    do m = 8'($urandom_range(2, 254));
    while (m >= BYTE_RST0 && m <= BYTE_EOI);
    return m;
  endfunction

  function automatic void push_segment(logic [7:0] code);
    int size;
    logic [15:0] size_field;
    size = ($urandom_range(0, 39) == 0) ? $urandom_range(9, 300) : $urandom_range(2, 8);
    size_field = 16'(size);
    push_marker(code);
    jpeg_bytes.push_back(size_field[15:8]);
    jpeg_bytes.push_back(size_field[7:0]);
    repeat (size - 2) jpeg_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void push_scan_data();
    logic [7:0] d;
    repeat ($urandom_range(0, 24)) begin
      case ($urandom_range(0, 9))
        0: push_marker(BYTE_00);
        1: push_marker(BYTE_RST0 + 8'($urandom_range(0, 7)));
        2: push_marker(BYTE_TEM);
        3: push_segment(plain_marker());
        default: begin
          do d = 8'($urandom_range(0, 255));
          while (d == BYTE_FF);
          jpeg_bytes.push_back(d);
        end
      endcase
    end
  endfunction

  function automatic void build_jpeg();
    jpeg_bytes.delete();
    jpeg_bytes.push_back(BYTE_FF);
    jpeg_bytes.push_back(BYTE_SOI);
    repeat ($urandom_range(0, 3)) push_segment(plain_marker());
    if ($urandom_range(0, 7) != 0) begin
      push_segment(BYTE_SOS);
      push_scan_data();
      if ($urandom_range(0, 3) == 0) begin
        push_segment(BYTE_SOS);
        push_scan_data();
      end
    end
    push_marker(BYTE_EOI);
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) jpeg_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic send_byte(logic [7:0] b, logic first, logic last);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat (pick_gap()) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data_byte = b;
    in_first_byte = first;
    in_last_byte = last;
    do @(posedge clk);
    while (in_stall);
    sb.note_byte(b, first, last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_stream(bit with_last, int stop_at);
    for (int i = 0; i <= stop_at; i++)
      send_byte(jpeg_bytes[i], i == 0, with_last && i == stop_at);
  endtask

  task automatic drain_verdicts();
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver: random stalls, with calm stretches between them
  initial begin
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
        if (stall_left == 0)
          calm_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(0, 4);
      end else begin
        out_stall = 1'b0;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) sb.check_verdict(out_complete);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int kind;
    int stop_at;
    int streams;
    bit with_last;
    sb = new;
    items_sent = 0;
    quiet_cycles = 0;
    streams = 0;
    sender_gaps = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_first_byte = 1'b0;
    in_last_byte = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // lone byte that both opens and ends a stream
    send_byte(BYTE_FF, 1'b1, 1'b1);
    // stream opening on a non-FF byte
    send_byte(BYTE_00, 1'b1, 1'b0);
    // stray byte while idle: no verdict
    send_byte(BYTE_FF, 1'b0, 1'b1);
    // minimal image with stuffing, RST, TEM and fill in scan data
    jpeg_bytes = '{BYTE_FF, BYTE_SOI, BYTE_FF, BYTE_SOS, 8'h00, 8'h02,
                   BYTE_FF, BYTE_00, BYTE_FF, BYTE_RST0, BYTE_FF, BYTE_TEM,
                   BYTE_FF, BYTE_FF, BYTE_EOI};
    send_stream(1'b1, jpeg_bytes.size() - 1);
    // length field below two
    jpeg_bytes = '{BYTE_FF, BYTE_SOI, BYTE_FF, BYTE_APP0, 8'h00, 8'h01};
    send_stream(1'b0, jpeg_bytes.size() - 1);
    drain_verdicts();

    while (items_sent < ITEM_TARGET) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        repeat ($urandom_range(1, 8))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                    $urandom_range(0, 3) == 0);
      end else begin
        build_jpeg();
        if (kind < 22)
          jpeg_bytes[$urandom_range(0, jpeg_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        stop_at = jpeg_bytes.size() - 1;
        if (kind >= 22 && kind < 36) stop_at = $urandom_range(0, jpeg_bytes.size() - 1);
        with_last = ($urandom_range(0, 4) != 0);
        send_stream(with_last, stop_at);
      end
      streams++;
      if (streams % 40 == 0) drain_verdicts();
    end

    drain_verdicts();
    repeat (10) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
